### hw/rtl/synth_voice_allocator_assert.svh
// Assertion macros for the voice allocator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define SVALLOC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that is also evaluated during reset.
`define SVALLOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVALLOC_ASSERT(lbl, clk, rst, prop, msg)
`define SVALLOC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/svalloc_pkg.sv
// Package for the voice allocator: field widths, codes and shared types.
// No dependencies.
`default_nettype none

package svalloc_pkg;

   localparam int unsigned NUM_VOICES_DEF = 9;
   localparam int unsigned NUM_CHANNELS   = 16;

   localparam int unsigned TYPE_W    = 2;
   localparam int unsigned CHAN_W    = 4;
   localparam int unsigned NOTE_W    = 7;
   localparam int unsigned SVOICE_W  = 4;
   localparam int unsigned VIDX_W    = 4;
   localparam int unsigned OUTCOME_W = 3;
   localparam int unsigned STAMP_W   = 32;

   // Request types.
   localparam logic [TYPE_W-1:0] REQ_NOTE_ON  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_NOTE_OFF = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SILENT   = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_ALL_OFF  = 2'd3;

   // Result outcomes.
   localparam logic [OUTCOME_W-1:0] OC_FREE      = 3'd0;
   localparam logic [OUTCOME_W-1:0] OC_STEAL_REL = 3'd1;
   localparam logic [OUTCOME_W-1:0] OC_STEAL_ACT = 3'd2;
   localparam logic [OUTCOME_W-1:0] OC_RELEASED  = 3'd3;
   localparam logic [OUTCOME_W-1:0] OC_FREED     = 3'd4;
   localparam logic [OUTCOME_W-1:0] OC_NONE      = 3'd5;

   typedef enum logic [2:0] {
      WR_NONE    = 3'd0,
      WR_ALLOC   = 3'd1,
      WR_RELEASE = 3'd2,
      WR_FREE    = 3'd3,
      WR_ALL_OFF = 3'd4
   } wr_op_type;

   typedef struct packed {
      wr_op_type           op;
      logic [CHAN_W-1:0]   chan;
      logic [NOTE_W-1:0]   note;
      logic [STAMP_W-1:0]  stamp;
   } wr_cmd_type;

   typedef struct packed {
      logic                active;
      logic                released;
      logic [CHAN_W-1:0]   owner;
      logic [NOTE_W-1:0]   note;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   typedef struct packed {
      logic is_free;
      logic is_match;
      logic better;
   } cmp_res_type;

endpackage

`default_nettype wire

### hw/rtl/svalloc_cmp_unit.sv
// Shared compare unit: judges one voice entry per cycle against the request
// key and the best stamp found so far. Depends on svalloc_pkg.
`default_nettype none

module svalloc_cmp_unit (
   input  svalloc_pkg::entry_type                    entry,
   input  logic [svalloc_pkg::CHAN_W-1:0]            key_chan,
   input  logic [svalloc_pkg::NOTE_W-1:0]            key_note,
   input  logic [svalloc_pkg::STAMP_W-1:0]           best_stamp,
   input  logic                                      best_found,
   input  logic                                      rel_only,
   output svalloc_pkg::cmp_res_type                  res
);
   import svalloc_pkg::*;

   logic eligible;

   assign eligible     = !rel_only || entry.released;
   assign res.is_free  = !entry.active;
   assign res.is_match = entry.active && !entry.released &&
                         (entry.owner == key_chan) && (entry.note == key_note);
   // Strict less-than keeps the lower index on a tie.
   assign res.better   = eligible && (!best_found || (entry.stamp < best_stamp));

endmodule

`default_nettype wire

### hw/rtl/svalloc_voice_file.sv
// Voice state registers: flag vectors plus owner, note and stamp per voice.
// One read port, one write command per cycle. Depends on svalloc_pkg.
`default_nettype none

module svalloc_voice_file #(
   parameter int unsigned NUM_VOICES = svalloc_pkg::NUM_VOICES_DEF,
   localparam int unsigned VW = $clog2(NUM_VOICES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [VW-1:0]               rd_idx,
   output svalloc_pkg::entry_type      rd_entry,
   input  logic [VW-1:0]               wr_idx,
   input  svalloc_pkg::wr_cmd_type     wr_cmd
);
   import svalloc_pkg::*;

   logic [NUM_VOICES-1:0] active_ff, active_in;
   logic [NUM_VOICES-1:0] released_ff, released_in;
   logic [CHAN_W-1:0]     owner_ff [NUM_VOICES];
   logic [NOTE_W-1:0]     note_ff  [NUM_VOICES];
   logic [STAMP_W-1:0]    stamp_ff [NUM_VOICES];

   always_comb begin
      active_in   = active_ff;
      released_in = released_ff;
      case (wr_cmd.op)
         WR_ALLOC: begin
            active_in[wr_idx]   = 1'b1;
            released_in[wr_idx] = 1'b0;
         end
         WR_RELEASE: begin
            released_in[wr_idx] = 1'b1;
         end
         WR_FREE: begin
            active_in[wr_idx] = 1'b0;
         end
         WR_ALL_OFF: begin
            released_in = released_ff | active_ff;
            active_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         released_ff <= '0;
      end else begin
         active_ff   <= active_in;
         released_ff <= released_in;
      end
   end

   // Owner, note and stamp are only read for voices that were allocated.
   always_ff @(posedge clock) begin
      if (wr_cmd.op == WR_ALLOC) begin
         owner_ff[wr_idx] <= wr_cmd.chan;
         note_ff[wr_idx]  <= wr_cmd.note;
         stamp_ff[wr_idx] <= wr_cmd.stamp;
      end
   end

   assign rd_entry.active   = active_ff[rd_idx];
   assign rd_entry.released = released_ff[rd_idx];
   assign rd_entry.owner    = owner_ff[rd_idx];
   assign rd_entry.note     = note_ff[rd_idx];
   assign rd_entry.stamp    = stamp_ff[rd_idx];

endmodule

`default_nettype wire

### hw/rtl/synth_voice_allocator.sv
// Voice allocator top level: request sequencer, age counter and result
// register. Uses svalloc_pkg, svalloc_voice_file and svalloc_cmp_unit.
//
//   channel   handshake            payload
//   request   start / busy         req_type, req_channel, req_note_number,
//                                  req_silent_voice
//   result    rsp_valid (strobe)   rsp_voice_index, rsp_outcome
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item finishes. The item is first decoded. Voice-silent, all-off
// and rejected items finish there. A note-off scans the voices one per cycle
// and stops at the first match or after the last voice. A note-on scans for
// a free voice while tracking the oldest released one, and when both fail it
// scans again for the oldest voice of all, in the shared compare unit. The
// result strobe rises the cycle after the item finishes and lasts one cycle;
// busy is already low then, so the next item may be taken in that cycle. The
// receiver cannot stall. Reset is synchronous and clears all voices and the
// age counter.
`default_nettype none
`include "synth_voice_allocator_assert.svh"

module synth_voice_allocator #(
   parameter int unsigned NUM_VOICES = svalloc_pkg::NUM_VOICES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [svalloc_pkg::TYPE_W-1:0]       req_type,
   input  logic [svalloc_pkg::CHAN_W-1:0]       req_channel,
   input  logic [svalloc_pkg::NOTE_W-1:0]       req_note_number,
   input  logic [svalloc_pkg::SVOICE_W-1:0]     req_silent_voice,
   output logic                                 rsp_valid,
   output logic [svalloc_pkg::VIDX_W-1:0]       rsp_voice_index,
   output logic [svalloc_pkg::OUTCOME_W-1:0]    rsp_outcome
);
   import svalloc_pkg::*;

   localparam int unsigned VW = $clog2(NUM_VOICES);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DECODE   = 5'b00010,
      ST_SCAN_REL = 5'b00100,
      ST_SCAN_ANY = 5'b01000,
      ST_SCAN_OFF = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // The latched request item.
   logic [TYPE_W-1:0]    type_ff, type_in;
   logic [CHAN_W-1:0]    chan_ff, chan_in;
   logic [NOTE_W-1:0]    note_ff, note_in;
   logic [SVOICE_W-1:0]  sv_ff, sv_in;

   // Scan position and the best candidate found so far.
   logic [VW-1:0]        idx_ff, idx_in;
   logic [VW-1:0]        best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0]   best_stamp_ff, best_stamp_in;
   logic                 best_found_ff, best_found_in;

   logic [STAMP_W-1:0]   age_ff, age_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VIDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [OUTCOME_W-1:0] rsp_oc_ff, rsp_oc_in;

   logic [VW-1:0]        rd_idx;
   logic [VW-1:0]        wr_idx;
   logic [VW-1:0]        sv_idx;
   logic [VW-1:0]        steal_idx;
   logic [31:0]          wide_idx;
   entry_type            entry;
   wr_cmd_type           wr_cmd;
   cmp_res_type          cmp;
   logic                 chan_ok;
   logic                 sv_ok;
   logic                 last_voice;

   assign chan_ok    = {28'd0, chan_ff} < 32'(NUM_CHANNELS);
   assign sv_ok      = {28'd0, sv_ff} < 32'(NUM_VOICES);
   assign sv_idx     = VW'(sv_ff);
   assign last_voice = (idx_ff == VW'(NUM_VOICES - 1));

   // The decode cycle reads the silent voice; scans read the scan position.
   assign rd_idx = (state_ff == ST_DECODE) ? sv_idx : idx_ff;

   // Candidate for a steal at the end of a pass: the voice under the
   // compare unit wins if it beats the best so far.
   assign steal_idx = cmp.better ? idx_ff : best_idx_ff;

   svalloc_voice_file #(
      .NUM_VOICES (NUM_VOICES)
   ) u_voice_file (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (entry),
      .wr_idx   (wr_idx),
      .wr_cmd   (wr_cmd)
   );

   svalloc_cmp_unit u_cmp_unit (
      .entry      (entry),
      .key_chan   (chan_ff),
      .key_note   (note_ff),
      .best_stamp (best_stamp_ff),
      .best_found (best_found_ff),
      .rel_only   (state_ff == ST_SCAN_REL),
      .res        (cmp)
   );

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      chan_in       = chan_ff;
      note_in       = note_ff;
      sv_in         = sv_ff;
      idx_in        = idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_found_in = best_found_ff;
      age_in        = age_ff;
      rsp_valid_in  = 1'b0;
      rsp_idx_in    = rsp_idx_ff;
      rsp_oc_in     = rsp_oc_ff;
      wr_idx        = idx_ff;
      wr_cmd.op     = WR_NONE;
      wr_cmd.chan   = chan_ff;
      wr_cmd.note   = note_ff;
      wr_cmd.stamp  = age_ff;
      wide_idx      = 32'(idx_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               type_in  = req_type;
               chan_in  = req_channel;
               note_in  = req_note_number;
               sv_in    = req_silent_voice;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            idx_in        = '0;
            best_found_in = 1'b0;
            case (type_ff)
               REQ_NOTE_ON, REQ_NOTE_OFF: begin
                  if (!chan_ok) begin
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = '0;
                     rsp_oc_in    = OC_NONE;
                     state_in     = ST_IDLE;
                  end else if (type_ff == REQ_NOTE_ON) begin
                     state_in = ST_SCAN_REL;
                  end else begin
                     state_in = ST_SCAN_OFF;
                  end
               end
               REQ_SILENT: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (sv_ok && entry.active && entry.released) begin
                     wr_idx     = sv_idx;
                     wr_cmd.op  = WR_FREE;
                     rsp_idx_in = sv_ff;
                     rsp_oc_in  = OC_FREED;
                  end else begin
                     rsp_idx_in = '0;
                     rsp_oc_in  = OC_NONE;
                  end
               end
               default: begin
                  // All notes off.
                  wr_cmd.op    = WR_ALL_OFF;
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = '0;
                  rsp_oc_in    = OC_FREED;
                  state_in     = ST_IDLE;
               end
            endcase
         end

         ST_SCAN_REL: begin
            if (cmp.is_free) begin
               // Lowest free voice: every voice before it is active.
               wr_cmd.op    = WR_ALLOC;
               age_in       = age_ff + 32'd1;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = wide_idx[VIDX_W-1:0];
               rsp_oc_in    = OC_FREE;
               state_in     = ST_IDLE;
            end else begin
               if (cmp.better) begin
                  best_idx_in   = idx_ff;
                  best_stamp_in = entry.stamp;
                  best_found_in = 1'b1;
               end
               if (last_voice) begin
                  if (best_found_ff || cmp.better) begin
                     wr_idx       = steal_idx;
                     wr_cmd.op    = WR_ALLOC;
                     age_in       = age_ff + 32'd1;
                     wide_idx     = 32'(steal_idx);
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = wide_idx[VIDX_W-1:0];
                     rsp_oc_in    = OC_STEAL_REL;
                     state_in     = ST_IDLE;
                  end else begin
                     // No released voice: look for the oldest of all.
                     idx_in        = '0;
                     best_found_in = 1'b0;
                     state_in      = ST_SCAN_ANY;
                  end
               end else begin
                  idx_in = idx_ff + VW'(1);
               end
            end
         end

         ST_SCAN_ANY: begin
            if (cmp.better) begin
               best_idx_in   = idx_ff;
               best_stamp_in = entry.stamp;
               best_found_in = 1'b1;
            end
            if (last_voice) begin
               wr_idx       = steal_idx;
               wr_cmd.op    = WR_ALLOC;
               age_in       = age_ff + 32'd1;
               wide_idx     = 32'(steal_idx);
               rsp_valid_in = 1'b1;
               rsp_idx_in   = wide_idx[VIDX_W-1:0];
               rsp_oc_in    = OC_STEAL_ACT;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + VW'(1);
            end
         end

         ST_SCAN_OFF: begin
            if (cmp.is_match) begin
               wr_cmd.op    = WR_RELEASE;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = wide_idx[VIDX_W-1:0];
               rsp_oc_in    = OC_RELEASED;
               state_in     = ST_IDLE;
            end else if (last_voice) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = '0;
               rsp_oc_in    = OC_NONE;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + VW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      chan_ff       <= chan_in;
      note_ff       <= note_in;
      sv_ff         <= sv_in;
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_found_ff <= best_found_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_oc_ff     <= rsp_oc_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voice_index = rsp_idx_ff;
   assign rsp_outcome     = rsp_oc_ff;

   // Strobes never touch: the state that raises one is followed by idle, which raises none.
   `SVALLOC_ASSERT(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe held two cycles")

   // An item only finishes together with its result.
   `SVALLOC_ASSERT(a_done_with_result, clock, reset, ($fell(busy) && !$past(reset)) |-> rsp_valid, "item finished without a result")

   // The age counter moves only when a note-on allocates a voice.
   `SVALLOC_ASSERT(a_age_on_alloc, clock, reset, ((age_ff != $past(age_ff)) && !$past(reset)) |-> (rsp_valid && (rsp_outcome == OC_FREE || rsp_outcome == OC_STEAL_REL || rsp_outcome == OC_STEAL_ACT)), "age counter moved without an allocation")

endmodule

`default_nettype wire
